@@ hw/rtl/swam_pkg.sv @@
// ----------------------------------------------------------------------------
// Segmented word allocator memory: shared definitions
// Sizes, request and status codes, and payload types used by the channel
// interfaces and the top level.
// ----------------------------------------------------------------------------
package swam_pkg;

   // Geometry
   localparam int MemoryBytes  = 1024;
   localparam int SegmentBytes = 256;
   localparam int WordCount    = MemoryBytes / 4;
   localparam int SegWords     = SegmentBytes / 4;
   localparam int SegCount     = MemoryBytes / SegmentBytes;

   localparam int AddrW    = 10;
   localparam int DataW    = 32;
   localparam int WordIdxW = $clog2(WordCount);
   localparam int SlotW    = $clog2(SegWords);
   localparam int SegW     = $clog2(SegCount);

   typedef logic [1:0]              req_kind_type;
   typedef logic [1:0]              pid_type;
   typedef logic [AddrW-1:0]        addr_type;
   typedef logic signed [DataW-1:0] data_type;
   typedef logic [1:0]              status_type;
   typedef logic [SegWords-1:0]     mark_row_type;

   // Request kinds
   localparam req_kind_type ReqAllocate = 2'd0;
   localparam req_kind_type ReqRead     = 2'd1;
   localparam req_kind_type ReqWrite    = 2'd2;
   localparam req_kind_type ReqKill     = 2'd3;

   // Result status
   localparam status_type StOk         = 2'd0;
   localparam status_type StMisaligned = 2'd1;
   localparam status_type StOutside    = 2'd2;
   localparam status_type StFull       = 2'd3;

endpackage

@@ hw/rtl/swam_if.sv @@
// ----------------------------------------------------------------------------
// Segmented word allocator memory: channel interfaces
// Valid/ready request and response channels; a transfer happens on a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface swam_req_if;
   logic                   valid;
   logic                   ready;
   swam_pkg::req_kind_type req_type;
   swam_pkg::pid_type      process_id;
   swam_pkg::addr_type     byte_address;
   swam_pkg::data_type     write_value;

   modport source (output valid, output req_type, output process_id,
                   output byte_address, output write_value, input ready);
   modport sink   (input valid, input req_type, input process_id,
                   input byte_address, input write_value, output ready);
endinterface

interface swam_rsp_if;
   logic                 valid;
   logic                 ready;
   swam_pkg::status_type status;
   swam_pkg::data_type   result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink   (input valid, input status, input result_value, output ready);
endinterface

@@ hw/rtl/segmented_word_allocator_memory.sv @@
// ----------------------------------------------------------------------------
// Segmented word allocator memory
// Word memory split into one fixed segment per process, with first-fit word
// allocation, checked read and write, and segment-wide free (kill).
// ----------------------------------------------------------------------------
// A request is taken in the idle state; its transfer cycle reads the word
// memory and the caller's row of allocation marks (both synchronous reads),
// and the access state runs the first-free priority encode over the 64 marks
// of that row, writes back the mark row or the word, and loads the response
// register. The access state stretches while a previous response still waits
// to be taken; a kill completes without a response and never waits. A new
// request is taken once the current one has finished, so one request is in
// flight at a time and no forwarding between requests is needed. There is no
// clearing pass after reset: a valid flop per word and per mark row, cleared
// by reset, makes unwritten entries read as zero, so requests are taken from
// the first cycle after reset.
// ----------------------------------------------------------------------------
module segmented_word_allocator_memory (
   input  logic        clock,
   input  logic        reset,
   swam_req_if.sink    req_chan,
   swam_rsp_if.source  rsp_chan
);

   // Sequencer states
   localparam logic StIdle   = 1'b0;
   localparam logic StAccess = 1'b1;

   logic state_ff, state_in;

   // Memories: one word per 4 bytes, one mark row per segment
   logic [swam_pkg::DataW-1:0]   word_mem [swam_pkg::WordCount];
   swam_pkg::mark_row_type       mark_mem [swam_pkg::SegCount];
   logic [swam_pkg::WordCount-1:0] word_vld_ff;
   logic [swam_pkg::SegCount-1:0]  row_vld_ff;

   // Captured request
   swam_pkg::req_kind_type kind_ff;
   swam_pkg::pid_type      pid_ff;
   swam_pkg::addr_type     addr_ff;
   swam_pkg::data_type     wval_ff;

   // Registered read data
   logic [swam_pkg::DataW-1:0] word_rd_ff;
   logic                       word_vld_rd_ff;
   swam_pkg::mark_row_type     mark_rd_ff;
   logic                       row_vld_rd_ff;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   swam_pkg::status_type rsp_status_ff;
   swam_pkg::data_type   rsp_value_ff;

   logic                          accept;
   logic                          done;
   logic                          is_kill;
   logic [swam_pkg::WordIdxW-1:0] req_widx;
   logic [swam_pkg::WordIdxW-1:0] cur_widx;
   logic [swam_pkg::SegW-1:0]     req_row;
   swam_pkg::mark_row_type        row_cur;
   logic                          found;
   logic [swam_pkg::SlotW-1:0]    slot;
   logic                          misaligned;
   logic                          outside;
   swam_pkg::status_type          status_c;
   swam_pkg::data_type            value_c;
   logic                          mark_we;
   swam_pkg::mark_row_type        mark_wdata;
   logic                          word_we;

   // Hold off transfers while reset is asserted
   assign req_chan.ready = (state_ff == StIdle) && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_widx = req_chan.byte_address[swam_pkg::AddrW-1:2];
   assign req_row  = req_chan.process_id[swam_pkg::SegW-1:0];
   assign cur_widx = addr_ff[swam_pkg::AddrW-1:2];

   // Finish when a kill, or when the response slot is free or being drained
   assign is_kill = (kind_ff == swam_pkg::ReqKill);
   assign done    = (state_ff == StAccess) &&
                    (is_kill || !rsp_valid_ff || rsp_chan.ready);

   // Unwritten mark rows read as all free
   assign row_cur = row_vld_rd_ff ? mark_rd_ff : '0;

   // First-fit: lowest free word of the segment
   always_comb begin
      found = 1'b0;
      slot  = '0;
      for (int i = swam_pkg::SegWords - 1; i >= 0; i--) begin
         if (!row_cur[i]) begin
            found = 1'b1;
            slot  = swam_pkg::SlotW'(i);
         end
      end
   end

   // Alignment first, then segment ownership
   assign misaligned = (addr_ff[1:0] != 2'b00);
   assign outside    = (addr_ff[swam_pkg::AddrW-1 -: swam_pkg::SegW] !=
                        pid_ff[swam_pkg::SegW-1:0]);

   always_comb begin
      status_c = swam_pkg::StOk;
      value_c  = '0;
      case (kind_ff)
         swam_pkg::ReqAllocate: begin
            if (found) begin
               value_c = swam_pkg::DataW'({pid_ff[swam_pkg::SegW-1:0], slot, 2'b00});
            end else begin
               status_c = swam_pkg::StFull;
            end
         end
         swam_pkg::ReqRead, swam_pkg::ReqWrite: begin
            if (misaligned) begin
               status_c = swam_pkg::StMisaligned;
            end else if (outside) begin
               status_c = swam_pkg::StOutside;
            end else if (kind_ff == swam_pkg::ReqRead && word_vld_rd_ff) begin
               value_c = word_rd_ff;
            end
         end
         default: begin
            status_c = swam_pkg::StOk;
            value_c  = '0;
         end
      endcase
   end

   // Write back: clear the row on kill, set the picked mark on allocate
   always_comb begin
      mark_we    = done && (is_kill || (kind_ff == swam_pkg::ReqAllocate && found));
      mark_wdata = row_cur;
      if (is_kill) begin
         mark_wdata = '0;
      end else begin
         mark_wdata[slot] = 1'b1;
      end
   end

   assign word_we = done && (kind_ff == swam_pkg::ReqWrite) && !misaligned && !outside;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle:   if (accept) state_in = StAccess;
         StAccess: if (done)   state_in = StIdle;
         default:  state_in = StIdle;
      endcase
   end

   // Drop the response on its transfer, load a new one on completion
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (done && !is_kill) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         word_vld_ff  <= '0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (word_we) word_vld_ff[cur_widx] <= 1'b1;
         if (mark_we) row_vld_ff[pid_ff[swam_pkg::SegW-1:0]] <= 1'b1;
      end
   end

   // Hold the request and its read data through the access cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff        <= req_chan.req_type;
         pid_ff         <= req_chan.process_id;
         addr_ff        <= req_chan.byte_address;
         wval_ff        <= req_chan.write_value;
         word_vld_rd_ff <= word_vld_ff[req_widx];
         row_vld_rd_ff  <= row_vld_ff[req_row];
      end
      if (done && !is_kill) begin
         rsp_status_ff <= status_c;
         rsp_value_ff  <= value_c;
      end
   end

   // Word memory
   always_ff @(posedge clock) begin
      if (word_we) word_mem[cur_widx] <= wval_ff;
      if (accept)  word_rd_ff <= word_mem[req_widx];
   end

   // Mark memory
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[pid_ff[swam_pkg::SegW-1:0]] <= mark_wdata;
      if (accept)  mark_rd_ff <= mark_mem[req_row];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.result_value = rsp_value_ff;

endmodule

@@ tb/sv/tb_segmented_word_allocator_memory.sv @@
// ----------------------------------------------------------------------------
// Testbench: segmented word allocator memory
// Drives allocate, read, write and kill requests over the request channel and
// checks every response against an in-bench model of the word store and the
// allocation marks. A short directed part comes first, then random traffic
// in three phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_segmented_word_allocator_memory;

   // Give up well past the slowest correct run, in time units.
   localparam int TimeoutUnits = 4_000_000;
   // Cycles to let pass after the last response, so a trailing kill settles.
   localparam int SettleCycles = 8;
   localparam int PhaseItems   = 300;

   typedef struct packed {
      swam_pkg::status_type status;
      swam_pkg::data_type   value;
   } swam_result_type;

   logic clock = 1'b0;
   logic reset;

   swam_req_if req_chan ();
   swam_rsp_if rsp_chan ();

   segmented_word_allocator_memory DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Model state: the word store and one allocation mark per word.
   swam_pkg::data_type word_image [swam_pkg::WordCount];
   bit                 mark_image [swam_pkg::WordCount];

   // Responses still owed by the block, oldest first.
   swam_result_type    expected_results [$];

   int                 error_count    = 0;
   int                 items_accepted = 0;
   int                 send_idle_pct  = 0;
   int                 recv_idle_pct  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Model: apply one request to the word and mark images and work out the
   // response it owes, if any.
   // -------------------------------------------------------------------------
   function automatic void predict_response(input swam_pkg::req_kind_type kind,
                                            input swam_pkg::pid_type pid,
                                            input swam_pkg::addr_type addr,
                                            input swam_pkg::data_type wval,
                                            output bit produces,
                                            output swam_pkg::status_type st,
                                            output swam_pkg::data_type val);
      int unsigned seg_lo;
      int unsigned seg_hi;
      int unsigned a;
      bit          found;
      seg_lo   = pid * swam_pkg::SegmentBytes;
      seg_hi   = seg_lo + swam_pkg::SegmentBytes;
      produces = 1'b1;
      st       = swam_pkg::StOk;
      val      = '0;
      found    = 1'b0;
      case (kind)
         swam_pkg::ReqKill: begin
            // Free the whole segment; the words keep their values.
            produces = 1'b0;
            for (a = (seg_lo + 3) & ~32'd3; a < seg_hi; a += 4)
               if (a < swam_pkg::MemoryBytes) mark_image[a >> 2] = 1'b0;
         end
         swam_pkg::ReqAllocate: begin
            // First fit over the aligned words of the segment inside memory.
            st = swam_pkg::StFull;
            for (a = (seg_lo + 3) & ~32'd3;
                 a < seg_hi && a < swam_pkg::MemoryBytes && !found; a += 4)
               if (!mark_image[a >> 2]) begin
                  mark_image[a >> 2] = 1'b1;
                  st    = swam_pkg::StOk;
                  val   = swam_pkg::data_type'(a);
                  found = 1'b1;
               end
         end
         default: begin
            // Alignment wins over the segment check.
            if (addr[1:0] != 2'b00)
               st = swam_pkg::StMisaligned;
            else if (!(addr >= seg_lo && addr < seg_hi && addr < swam_pkg::MemoryBytes))
               st = swam_pkg::StOutside;
            else if (kind == swam_pkg::ReqRead)
               val = word_image[(addr >> 2) % swam_pkg::WordCount];
            else
               word_image[(addr >> 2) % swam_pkg::WordCount] = wval;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // -------------------------------------------------------------------------
   // Response side: randomize ready each cycle and check every transfer
   // against the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      swam_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", {rsp_chan.status, 30'd0},
                            rsp_chan.result_value);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            if (rsp_chan.result_value !== want.value)
               report_mismatch("result_value", rsp_chan.result_value, want.value);
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // -------------------------------------------------------------------------
   // Request side: idle at random, then hold one request until its transfer,
   // and record what it owes. Valid stays high on return so back-to-back
   // requests need no drop in between.
   // -------------------------------------------------------------------------
   task automatic send_request(input swam_pkg::req_kind_type kind,
                               input swam_pkg::pid_type pid,
                               input swam_pkg::addr_type addr,
                               input swam_pkg::data_type wval);
      bit                   produces;
      swam_pkg::status_type st;
      swam_pkg::data_type   val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= kind;
      req_chan.process_id   <= pid;
      req_chan.byte_address <= addr;
      req_chan.write_value  <= wval;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_response(kind, pid, addr, wval, produces, st, val);
      if (produces) expected_results.push_back('{status: st, value: val});
      items_accepted++;
   endtask

   // Drop valid and hold off until every owed response has arrived.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Directed tests
   // -------------------------------------------------------------------------

   // Memory comes out of reset zeroed.
   task automatic test_reset_contents();
      send_request(swam_pkg::ReqRead, 2'd0, 10'd0, swam_pkg::data_type'($urandom()));
      send_request(swam_pkg::ReqRead, 2'd3, 10'd1020, swam_pkg::data_type'($urandom()));
   endtask

   // Allocations hand out the lowest free word, per segment.
   task automatic test_first_fit();
      repeat (3) send_request(swam_pkg::ReqAllocate, 2'd0, 10'd0, '0);
      send_request(swam_pkg::ReqAllocate, 2'd3, 10'd1023, '1);
   endtask

   // Extreme values at the lowest and highest word, read back.
   task automatic test_write_read();
      send_request(swam_pkg::ReqWrite, 2'd0, 10'd0, 32'sh7FFF_FFFF);
      send_request(swam_pkg::ReqWrite, 2'd3, 10'd1020, 32'h8000_0000);
      send_request(swam_pkg::ReqWrite, 2'd1, 10'd256, -32'sd1);
      send_request(swam_pkg::ReqRead, 2'd0, 10'd0, '0);
      send_request(swam_pkg::ReqRead, 2'd3, 10'd1020, '0);
      send_request(swam_pkg::ReqRead, 2'd1, 10'd256, '0);
   endtask

   // Misaligned addresses, including one also outside the segment.
   task automatic test_alignment();
      send_request(swam_pkg::ReqRead, 2'd0, 10'd1, '0);
      send_request(swam_pkg::ReqWrite, 2'd2, 10'd515, 32'sh1234_5678);
      send_request(swam_pkg::ReqRead, 2'd0, 10'd1023, '0);
   endtask

   // Addresses just past either end of the caller's segment, and its last word.
   task automatic test_segment_bounds();
      send_request(swam_pkg::ReqRead, 2'd0, 10'd256, '0);
      send_request(swam_pkg::ReqWrite, 2'd1, 10'd252, 32'sh0BAD_F00D);
      send_request(swam_pkg::ReqRead, 2'd1, 10'd508, '0);
   endtask

   // Kill frees marks only: allocation restarts at the base, data survives.
   task automatic test_kill();
      send_request(swam_pkg::ReqKill, 2'd0, 10'd0, '0);
      send_request(swam_pkg::ReqAllocate, 2'd0, 10'd0, '0);
      send_request(swam_pkg::ReqRead, 2'd0, 10'd0, '0);
      send_request(swam_pkg::ReqKill, 2'd2, 10'd1023, '1);
   endtask

   // -------------------------------------------------------------------------
   // Random traffic: bursts of allocation deep enough to fill segments,
   // in-segment read/write bursts, kills, and a share of raw noise.
   // -------------------------------------------------------------------------
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int                 phase_end;
      int                 pick;
      int                 burst;
      swam_pkg::pid_type  pid;
      swam_pkg::addr_type addr;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_end     = items_accepted + PhaseItems;
      while (items_accepted < phase_end) begin
         pick  = $urandom_range(99);
         pid   = swam_pkg::pid_type'($urandom_range(3));
         if (pick < 25) begin
            // Allocation burst, often long enough to run into a full segment.
            burst = $urandom_range(1, swam_pkg::SegWords + 8);
            repeat (burst) send_request(swam_pkg::ReqAllocate, pid,
                                        swam_pkg::addr_type'($urandom()),
                                        swam_pkg::data_type'($urandom()));
         end else if (pick < 62) begin
            // Aligned reads and writes inside the segment; favor a few low
            // words so reads often return data written earlier.
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               addr = swam_pkg::addr_type'(pid * swam_pkg::SegmentBytes +
                         4 * ($urandom_range(1) ? $urandom_range(7) :
                                 $urandom_range(swam_pkg::SegWords - 1)));
               send_request($urandom_range(1) ? swam_pkg::ReqRead : swam_pkg::ReqWrite,
                            pid, addr, swam_pkg::data_type'($urandom()));
            end
         end else if (pick < 70) begin
            send_request(swam_pkg::ReqKill, pid, swam_pkg::addr_type'($urandom()),
                         swam_pkg::data_type'($urandom()));
         end else begin
            // Noise: every field over its full range.
            burst = $urandom_range(1, 4);
            repeat (burst)
               send_request(swam_pkg::req_kind_type'($urandom_range(3)),
                            swam_pkg::pid_type'($urandom_range(3)),
                            swam_pkg::addr_type'($urandom_range(swam_pkg::MemoryBytes - 1)),
                            swam_pkg::data_type'($urandom()));
         end
      end
      hold_until_drained();
   endtask

   // -------------------------------------------------------------------------
   // Sequence: reset once, directed part, then three random phases.
   // -------------------------------------------------------------------------
   initial begin
      foreach (word_image[i]) word_image[i] = '0;
      foreach (mark_image[i]) mark_image[i] = 1'b0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= swam_pkg::ReqAllocate;
      req_chan.process_id   <= '0;
      req_chan.byte_address <= '0;
      req_chan.write_value  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_first_fit();
      test_write_read();
      test_alignment();
      test_segment_bounds();
      test_kill();
      // Pause the sender until the block has answered everything.
      hold_until_drained();

      test_random_traffic(27, 84);
      test_random_traffic(84, 27);
      test_random_traffic(0, 0);

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TimeoutUnits);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/swam_pkg.sv
hw/rtl/swam_if.sv
hw/rtl/segmented_word_allocator_memory.sv
tb/sv/tb_segmented_word_allocator_memory.sv
